>>> hw/rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int HEAP_GRANULES = 256;

	// granule index and block length widths
	localparam int GW = $clog2(HEAP_GRANULES);
	localparam int LW = $clog2(HEAP_GRANULES + 1);

	localparam int SIZE_W = 13;
	localparam int ADDR_W = 12;

	localparam int GRAN_SHIFT = 4;
	localparam int HDR_BYTES  = 8;
	localparam int NEED_BIAS  = HDR_BYTES + (1 << GRAN_SHIFT) - 1;

	// width of the granule count needed by the largest request
	localparam int NW = SIZE_W + 1 - GRAN_SHIFT;
	localparam int CW = (LW > NW) ? LW : NW;
	localparam int DW = CW + 1;
	localparam int OW = (GW + GRAN_SHIFT > ADDR_W) ? GW + GRAN_SHIFT : ADDR_W;

	localparam logic REQ_FREE = 1'b1;

	typedef logic [LW-1:0] len_t;
	typedef logic [GW-1:0] gidx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADPTR  = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	typedef struct packed {
		logic used;
		len_t len;
	} hdr_t;

	typedef struct packed {
		logic  we;
		gidx_t waddr;
		hdr_t  wdata;
		logic  re;
		gidx_t raddr;
	} ram_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_FREE_NX,
		S_FREE_PV,
		S_SPLIT,
		S_DONE
	} state_t;

endpackage

>>> hw/rtl/ffha_if.sv
interface ffha_req_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SIZE_W-1:0] req_size;
	logic [ADDR_W-1:0] req_addr;

	modport source(output valid, req_type, req_size, req_addr, input ready);
	modport sink(input valid, req_type, req_size, req_addr, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [ADDR_W-1:0] payload_addr;

	modport source(output valid, status, payload_addr, input ready);
	modport sink(input valid, status, payload_addr, output ready);
endinterface

>>> hw/rtl/ffha_ram.sv
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp,
	output ram_req_t   ram_req,
	input  hdr_t       ram_rdata
);

	state_t state_q, state_d;

	logic              type_q;
	logic [NW-1:0]     need_q;
	logic [ADDR_W-1:0] addr_q;
	len_t              pos_q;
	len_t              len_q;
	len_t              nx_q;
	len_t              split_pos_q;
	gidx_t             prev_pos_q;
	len_t              prev_len_q;
	logic              prev_free_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;

	logic e0_wr_q;
	logic rd_zero_q;

	hdr_t              cur;
	logic              alloc;
	logic              ok;
	logic              fit;
	logic              split;
	logic              match;
	logic              nx_free;
	logic              out_free;
	logic [OW-1:0]     off_w;
	logic [SIZE_W:0]   need_sum;
	logic [DW-1:0]     opa, opb, sum;
	logic              sub;

	function automatic logic blk_ok(len_t pos, len_t len);
		logic r;
		r = (pos < LW'(HEAP_GRANULES)) && (len != '0)
			&& (len <= LW'(HEAP_GRANULES) - pos);
		return r;
	endfunction

	// entry 0 holds the whole arena until its first write
	assign cur = (rd_zero_q && !e0_wr_q) ? '{used: 1'b0, len: LW'(HEAP_GRANULES)} : ram_rdata;

	assign alloc    = (type_q != REQ_FREE);
	assign ok       = blk_ok(pos_q, cur.len);
	assign fit      = !cur.used && (CW'(cur.len) >= CW'(need_q));
	assign split    = CW'(cur.len) > CW'(need_q);
	assign off_w    = (OW'(pos_q[GW-1:0]) << GRAN_SHIFT) + OW'(HDR_BYTES);
	assign match    = (off_w == OW'(addr_q));
	assign nx_free  = blk_ok(nx_q, cur.len) && !cur.used;
	assign out_free = !out_valid_q || rsp.ready;
	assign need_sum = {1'b0, req.req_size} + (SIZE_W + 1)'(NEED_BIAS);

	// the shared adder
	assign sum = sub ? (opa - opb) : (opa + opb);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.req_type != REQ_FREE && req.req_size == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (!ok) begin
					state_d = S_DONE;
				end else if (alloc) begin
					if (fit) begin
						state_d = split ? S_SPLIT : S_DONE;
					end
				end else if (match) begin
					state_d = cur.used ? S_FREE_NX : S_DONE;
				end
			end
			S_FREE_NX: state_d = prev_free_q ? S_FREE_PV : S_DONE;
			S_FREE_PV: state_d = S_DONE;
			S_SPLIT:   state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_req = '0;
		opa     = '0;
		opb     = '0;
		sub     = 1'b0;
		case (state_q)
			S_IDLE: begin
				ram_req.re = req.valid;
			end
			S_WALK: begin
				opa           = DW'(pos_q);
				opb           = (alloc && fit) ? DW'(need_q) : DW'(cur.len);
				ram_req.re    = 1'b1;
				ram_req.raddr = sum[GW-1:0];
				if (ok && alloc && fit) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = pos_q[GW-1:0];
					ram_req.wdata = '{used: 1'b1, len: LW'(need_q)};
				end
			end
			S_FREE_NX: begin
				opa           = DW'(len_q);
				opb           = nx_free ? DW'(cur.len) : '0;
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q[GW-1:0];
				ram_req.wdata = '{used: 1'b0, len: LW'(sum)};
			end
			S_FREE_PV: begin
				opa           = DW'(prev_len_q);
				opb           = DW'(len_q);
				ram_req.we    = 1'b1;
				ram_req.waddr = prev_pos_q;
				ram_req.wdata = '{used: 1'b0, len: LW'(sum)};
			end
			S_SPLIT: begin
				opa           = DW'(len_q);
				opb           = DW'(need_q);
				sub           = 1'b1;
				ram_req.we    = 1'b1;
				ram_req.waddr = split_pos_q[GW-1:0];
				ram_req.wdata = '{used: 1'b0, len: LW'(sum)};
			end
			default: ;
		endcase
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.payload_addr = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			e0_wr_q     <= 1'b0;
			rd_zero_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_req.we && ram_req.waddr == '0) begin
				e0_wr_q <= 1'b1;
			end
			if (ram_req.re) begin
				rd_zero_q <= (ram_req.raddr == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
		end
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					type_q       <= req.req_type;
					need_q       <= need_sum[SIZE_W:GRAN_SHIFT];
					addr_q       <= req.req_addr;
					pos_q        <= '0;
					prev_free_q  <= 1'b0;
					res_status_q <= ST_NOSPACE;
					res_addr_q   <= '0;
				end
			end
			S_WALK: begin
				if (!ok) begin
					res_status_q <= alloc ? ST_NOSPACE : ST_BADPTR;
				end else if (alloc) begin
					if (fit) begin
						res_status_q <= ST_OK;
						res_addr_q   <= off_w[ADDR_W-1:0];
						split_pos_q  <= LW'(sum);
						len_q        <= cur.len;
					end else begin
						pos_q <= LW'(sum);
					end
				end else if (match) begin
					if (cur.used) begin
						len_q <= cur.len;
						nx_q  <= LW'(sum);
					end else begin
						res_status_q <= ST_DOUBLE;
					end
				end else begin
					prev_pos_q  <= pos_q[GW-1:0];
					prev_len_q  <= cur.len;
					prev_free_q <= !cur.used;
					pos_q       <= LW'(sum);
				end
			end
			S_FREE_NX: begin
				len_q        <= LW'(sum);
				res_status_q <= ST_OK;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_split_in_arena: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> (split_pos_q < LW'(HEAP_GRANULES)))
		else $error("split point outside arena");

	a_prev_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE_PV) |-> ($past(state_q) == S_FREE_NX) && prev_free_q)
		else $error("merge with previous block that is not free");

	a_walk_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (pos_q <= LW'(HEAP_GRANULES)))
		else $error("walk position past arena end");

	a_alloc_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_status_q == ST_OK && alloc)
		|-> (res_addr_q[GRAN_SHIFT-1:0] == GRAN_SHIFT'(HDR_BYTES)))
		else $error("allocated offset not at a payload start");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (state_q != S_IDLE && state_q != S_DONE))
		else $error("header write outside a walk or update");
`endif

endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over an arena of HEAP_GRANULES 16-byte granules.
// req channel: one word per request (req_type 0 allocate, 1 free; req_size
// for allocate, req_addr payload offset for free). rsp channel: one word per
// request with status and payload_addr, in request order.
// Each request walks the block headers from granule 0, one header per cycle
// through the single read port of the header RAM. The walk ends at the first
// fitting block (allocate), at the block named by a free (clear or double
// free), or when it runs off the arena end. A fit larger than needed then
// splits off the remainder; a free clears its header, joining a free next
// block, and then merges with the previous block if that one is free. A
// zero-size allocate answers without a walk.
// req.ready is high only in the idle state between requests, so requests
// are handled one at a time.
// Reset leaves the arena as one free block: header 0 reads as the whole
// arena until first written, so there is no clearing pass after reset.
// The result sits in an output register; while the receiver stalls, one
// more request is accepted and walked, then held until the register frees.
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);

	ram_req_t ram_req;
	hdr_t     ram_rdata;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	ffha_ram #(
		.WIDTH ($bits(hdr_t)),
		.DEPTH (HEAP_GRANULES)
	) u_hdr_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule
